// File: sv/mips_branch_target_resolver_assert.svh
// Assertion macros for the MIPS branch target resolver.
`ifndef MIPS_BRANCH_TARGET_RESOLVER_ASSERT_SVH
`define MIPS_BRANCH_TARGET_RESOLVER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, sampled on clk, off during reset.
`define MBTR_ASSERT_IMPLY(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication with a fixed delay in cycles.
`define MBTR_ASSERT_DELAY(name, ante, dly, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
    else $error(msg);

`else

`define MBTR_ASSERT_IMPLY(name, ante, cons, msg)
`define MBTR_ASSERT_DELAY(name, ante, dly, cons, msg)

`endif

`endif

// File: sv/mbtr_pkg.sv
// Shared types and constants for the MIPS branch target resolver.
package mbtr_pkg;

  localparam int WORD_WIDTH_DEF = 32;
  localparam int PIPE_DEPTH     = 3;

  // Result status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_UNALIGNED  = 2'd1;
  localparam logic [1:0] ST_NOT_BRANCH = 2'd2;

  // Primary opcodes
  localparam logic [5:0] OP_SPECIAL = 6'd0;
  localparam logic [5:0] OP_REGIMM  = 6'd1;
  localparam logic [5:0] OP_J       = 6'd2;
  localparam logic [5:0] OP_JAL     = 6'd3;
  localparam logic [5:0] OP_BEQ     = 6'd4;
  localparam logic [5:0] OP_BNE     = 6'd5;
  localparam logic [5:0] OP_BLEZ    = 6'd6;
  localparam logic [5:0] OP_BGTZ    = 6'd7;
  localparam logic [5:0] OP_COP1    = 6'd17;
  localparam logic [5:0] OP_BEQL    = 6'd20;
  localparam logic [5:0] OP_BNEL    = 6'd21;
  localparam logic [5:0] OP_BLEZL   = 6'd22;
  localparam logic [5:0] OP_BGTZL   = 6'd23;

  // SPECIAL function codes
  localparam logic [5:0] FN_JR   = 6'd8;
  localparam logic [5:0] FN_JALR = 6'd9;

  // COP1 branch sub-op in the rs field
  localparam logic [4:0] RS_BC = 5'd8;

  localparam int         FP_COND_BIT  = 23;
  localparam logic [4:0] LINK_REG     = 5'd31;
  localparam int         REGION_SHIFT = 28;

  typedef enum logic [3:0] {
    K_NONE,
    K_UNAL,
    K_JR,
    K_JUMP,
    K_REGIMM,
    K_BEQ,
    K_BNE,
    K_BLEZ,
    K_BGTZ,
    K_BC1
  } kind_t;

  // Decode stage control word
  typedef struct packed {
    kind_t      kind;
    logic       link_en;
    logic [4:0] link_idx;
    logic       link_self;  // jalr with rd == rs: target is the link value
    logic       sense;      // rt[0]: gez / bc1t
    logic       fp_cond;
  } dec_t;

  // Evaluate stage control word
  typedef struct packed {
    kind_t      kind;
    logic       link_en;
    logic [4:0] link_idx;
    logic       link_self;
    logic       taken;
  } res_t;

endpackage

// File: sv/mbtr_decode.sv
// Stage 1: instruction decode and register-zero operand fixup.
module mbtr_decode
  import mbtr_pkg::*;
#(
  parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic [31:0]           pc,
  input  logic [31:0]           instruction,
  input  logic signed [31:0]    rs_value,
  input  logic signed [31:0]    rt_value,
  input  logic [31:0]           fp_status,
  output logic                  out_valid,
  output dec_t                  dec,
  output logic [WORD_WIDTH-1:0] pc_w,
  output logic [WORD_WIDTH-1:0] a,
  output logic [WORD_WIDTH-1:0] b,
  output logic [15:0]           imm,
  output logic [25:0]           jidx
);

  logic [5:0] op;
  logic [4:0] rs;
  logic [4:0] rt;
  logic [4:0] rd;
  logic [5:0] fn;
  dec_t       dec_next;

  assign op = instruction[31:26];
  assign rs = instruction[25:21];
  assign rt = instruction[20:16];
  assign rd = instruction[15:11];
  assign fn = instruction[5:0];

  always_comb begin
    dec_next           = '0;
    dec_next.kind      = K_NONE;
    dec_next.sense     = rt[0];
    dec_next.fp_cond   = fp_status[FP_COND_BIT];
    if (pc[1:0] != 2'b00) begin
      dec_next.kind = K_UNAL;
    end else begin
      case (op)
        OP_SPECIAL: begin
          if (fn == FN_JR || fn == FN_JALR) begin
            dec_next.kind = K_JR;
            if (fn == FN_JALR && rd != 5'd0) begin
              dec_next.link_en   = 1'b1;
              dec_next.link_idx  = rd;
              dec_next.link_self = (rd == rs);
            end
          end
        end
        OP_REGIMM: begin
          // bltz/bgez, likely and link forms
          if (rt[3:2] == 2'b00) begin
            dec_next.kind = K_REGIMM;
            if (rt[4]) begin
              dec_next.link_en  = 1'b1;
              dec_next.link_idx = LINK_REG;
            end
          end
        end
        OP_J: dec_next.kind = K_JUMP;
        OP_JAL: begin
          dec_next.kind     = K_JUMP;
          dec_next.link_en  = 1'b1;
          dec_next.link_idx = LINK_REG;
        end
        OP_BEQ, OP_BEQL:   dec_next.kind = K_BEQ;
        OP_BNE, OP_BNEL:   dec_next.kind = K_BNE;
        OP_BLEZ, OP_BLEZL: dec_next.kind = K_BLEZ;
        OP_BGTZ, OP_BGTZL: dec_next.kind = K_BGTZ;
        OP_COP1: begin
          if (rs == RS_BC && rt[4:2] == 3'b000) begin
            dec_next.kind = K_BC1;
          end
        end
        default: dec_next.kind = K_NONE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    dec  <= dec_next;
    pc_w <= WORD_WIDTH'(pc);
    a    <= (rs != 5'd0) ? WORD_WIDTH'(rs_value) : '0;
    b    <= (rt != 5'd0) ? WORD_WIDTH'(rt_value) : '0;
    imm  <= instruction[15:0];
    jidx <= instruction[25:0];
  end

endmodule

// File: sv/mbtr_eval.sv
// Stage 2: condition evaluation and target address arithmetic.
module mbtr_eval
  import mbtr_pkg::*;
#(
  parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  dec_t                  dec,
  input  logic [WORD_WIDTH-1:0] pc_w,
  input  logic [WORD_WIDTH-1:0] a,
  input  logic [WORD_WIDTH-1:0] b,
  input  logic [15:0]           imm,
  input  logic [25:0]           jidx,
  output logic                  out_valid,
  output res_t                  res,
  output logic [WORD_WIDTH-1:0] pc_r,
  output logic [WORD_WIDTH-1:0] taken_pc,
  output logic [WORD_WIDTH-1:0] fall_pc,
  output logic [WORD_WIDTH-1:0] tgt
);

  logic                  eq;
  logic                  neg;
  logic                  zero;
  logic                  taken;
  logic [WORD_WIDTH-1:0] off;
  logic [WORD_WIDTH-1:0] pc4;
  logic [WORD_WIDTH-1:0] region;
  logic [WORD_WIDTH-1:0] jtgt;
  res_t                  res_next;

  assign eq   = (a == b);
  assign neg  = a[WORD_WIDTH-1];
  assign zero = (a == '0);

  always_comb begin
    case (dec.kind)
      K_REGIMM: taken = dec.sense ? !neg : neg;
      K_BEQ:    taken = eq;
      K_BNE:    taken = !eq;
      K_BLEZ:   taken = neg || zero;
      K_BGTZ:   taken = !(neg || zero);
      K_BC1:    taken = dec.sense ? dec.fp_cond : !dec.fp_cond;
      default:  taken = 1'b0;
    endcase
  end

  // word offset, sign extended to the address width
  assign off    = WORD_WIDTH'(signed'({imm, 2'b00}));
  assign pc4    = pc_w + WORD_WIDTH'(4);
  assign region = (pc4 >> REGION_SHIFT) << REGION_SHIFT;
  assign jtgt   = region | WORD_WIDTH'({jidx, 2'b00});

  always_comb begin
    res_next.kind      = dec.kind;
    res_next.link_en   = dec.link_en;
    res_next.link_idx  = dec.link_idx;
    res_next.link_self = dec.link_self;
    res_next.taken     = taken;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    res      <= res_next;
    pc_r     <= pc_w;
    taken_pc <= pc_w + WORD_WIDTH'(4) + off;
    fall_pc  <= pc_w + WORD_WIDTH'(8);
    tgt      <= (dec.kind == K_JR) ? a : jtgt;
  end

endmodule

// File: sv/mbtr_select.sv
// Stage 3: next-pc and link selection into the result registers.
module mbtr_select
  import mbtr_pkg::*;
#(
  parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  res_t                  res,
  input  logic [WORD_WIDTH-1:0] pc_r,
  input  logic [WORD_WIDTH-1:0] taken_pc,
  input  logic [WORD_WIDTH-1:0] fall_pc,
  input  logic [WORD_WIDTH-1:0] tgt,
  output logic                  done,
  output logic [1:0]            status,
  output logic [31:0]           next_pc,
  output logic                  link_write,
  output logic [4:0]            link_index,
  output logic [31:0]           link_value
);

  logic [WORD_WIDTH-1:0] npc;
  logic [1:0]            status_next;

  always_comb begin
    case (res.kind)
      K_UNAL: begin
        npc         = pc_r;
        status_next = ST_UNALIGNED;
      end
      K_NONE: begin
        npc         = pc_r;
        status_next = ST_NOT_BRANCH;
      end
      K_JR, K_JUMP: begin
        npc         = res.link_self ? fall_pc : tgt;
        status_next = ST_OK;
      end
      default: begin
        npc         = res.taken ? taken_pc : fall_pc;
        status_next = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    status     <= status_next;
    next_pc    <= npc[31:0];
    link_write <= res.link_en;
    link_index <= res.link_en ? res.link_idx : 5'd0;
    link_value <= res.link_en ? fall_pc[31:0] : 32'd0;
  end

endmodule

// File: sv/mips_branch_target_resolver.sv
// Top level of the MIPS32 branch target resolver.
//
// Usage:
//   Command channel: drive start high with pc, instruction, rs_value,
//   rt_value and fp_status; the word is taken at the rising edge where
//   start is high and busy is low. busy is always low: a new word may be
//   issued in every cycle.
//   Result channel: done pulses for one cycle with status, next_pc,
//   link_write, link_index and link_value. The receiver has no back
//   pressure and must take the result in that cycle.
//   Pipeline: the decode, evaluate and select registers lie between accept
//   and done. Throughput: one word per cycle; every stage takes a new
//   word each cycle and nothing waits. The evaluate stage holds the
//   pc + 4 + offset add and the compares, the longest path.
//   Address arithmetic runs at WORD_WIDTH bits; outputs keep the low 32.
//   Status: 0 resolved, 1 unaligned pc (nothing decoded, next_pc = pc),
//   2 not a handled branch (next_pc = pc, no link write).
//   Reset (rst, synchronous) clears the stage valid bits, so words in
//   flight are dropped and done stays low until new words arrive.
module mips_branch_target_resolver
  import mbtr_pkg::*;
#(
  parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [31:0]        pc,
  input  logic [31:0]        instruction,
  input  logic signed [31:0] rs_value,
  input  logic signed [31:0] rt_value,
  input  logic [31:0]        fp_status,
  output logic               done,
  output logic [1:0]         status,
  output logic [31:0]        next_pc,
  output logic               link_write,
  output logic [4:0]         link_index,
  output logic [31:0]        link_value
);

  `include "mips_branch_target_resolver_assert.svh"

  // stage 1 -> 2
  logic                  v1;
  dec_t                  dec;
  logic [WORD_WIDTH-1:0] pc_w;
  logic [WORD_WIDTH-1:0] a;
  logic [WORD_WIDTH-1:0] b;
  logic [15:0]           imm;
  logic [25:0]           jidx;

  // stage 2 -> 3
  logic                  v2;
  res_t                  res;
  logic [WORD_WIDTH-1:0] pc_r;
  logic [WORD_WIDTH-1:0] taken_pc;
  logic [WORD_WIDTH-1:0] fall_pc;
  logic [WORD_WIDTH-1:0] tgt;

  // Fully pipelined, never stalls.
  assign busy = 1'b0;

  mbtr_decode #(
    .WORD_WIDTH (WORD_WIDTH)
  ) u_decode (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (start && !busy),
    .pc          (pc),
    .instruction (instruction),
    .rs_value    (rs_value),
    .rt_value    (rt_value),
    .fp_status   (fp_status),
    .out_valid   (v1),
    .dec         (dec),
    .pc_w        (pc_w),
    .a           (a),
    .b           (b),
    .imm         (imm),
    .jidx        (jidx)
  );

  mbtr_eval #(
    .WORD_WIDTH (WORD_WIDTH)
  ) u_eval (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v1),
    .dec       (dec),
    .pc_w      (pc_w),
    .a         (a),
    .b         (b),
    .imm       (imm),
    .jidx      (jidx),
    .out_valid (v2),
    .res       (res),
    .pc_r      (pc_r),
    .taken_pc  (taken_pc),
    .fall_pc   (fall_pc),
    .tgt       (tgt)
  );

  mbtr_select #(
    .WORD_WIDTH (WORD_WIDTH)
  ) u_select (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (v2),
    .res        (res),
    .pc_r       (pc_r),
    .taken_pc   (taken_pc),
    .fall_pc    (fall_pc),
    .tgt        (tgt),
    .done       (done),
    .status     (status),
    .next_pc    (next_pc),
    .link_write (link_write),
    .link_index (link_index),
    .link_value (link_value)
  );

  // Every accepted word comes out on done once it has passed the pipeline.
  `MBTR_ASSERT_DELAY(a_latency, start && !busy, PIPE_DEPTH, done, "word lost in pipeline")
  // Unresolved words never write a link register.
  `MBTR_ASSERT_IMPLY(a_no_link_unres, done && status != ST_OK, !link_write, "link on unresolved")
  // Writes to register zero are discarded.
  `MBTR_ASSERT_IMPLY(a_link_nonzero, done && link_write, link_index != 5'd0, "link to r0")
  // Unaligned status passes the faulting pc through.
  `MBTR_ASSERT_IMPLY(a_unal_pc, done && status == ST_UNALIGNED, next_pc[1:0] != 2'b00,
                     "unaligned status with aligned pc")

endmodule
